[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check wrappers, synchronous active-low reset disables.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, disabled while reset is asserted.
`define BAM_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true outside reset.
`define BAM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/bam_pkg.sv]
// ---------------------------------------------------------------------------
// bam_pkg
// Widths, command codes, sequencer states and shared types of the map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bam_pkg;

    localparam int MAP_BYTES_DEF = 128;

    localparam int CFG_W   = 8;
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int POS_W   = 11;   // bit position, map holds at most 255 bytes in use
    localparam int RUN_W   = 12;
    localparam int WORD_W  = 64;
    localparam int WORD_BYTES = 8;
    localparam int OFF_W   = 6;    // bit offset inside a word
    localparam int WIDX_W  = 5;    // word index over the addressable map
    localparam int CHUNK_W = 8;    // bits examined per scan step
    localparam int CSEL_W  = 3;    // chunk select inside a word
    localparam int LR_W    = 4;

    localparam logic [CFG_W-1:0]  MAP_BYTES_RST = 8'd128;
    localparam logic [OFF_W-1:0]  OFF_MAX       = 6'd63;
    localparam logic [CSEL_W-1:0] LAST_CHUNK    = 3'd7;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TEST  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RANGE = 3'd4;

    typedef enum logic [3:0] {
        S_INIT,
        S_CLR,
        S_IDLE,
        S_TEST_RD,
        S_TEST_DAT,
        S_RNG_RD,
        S_RNG_WR,
        S_SCAN_RD,
        S_SCAN_RUN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
        logic [RUN_W-1:0] run;
        logic [POS_W-1:0] first;
    } t_run_res;

endpackage

[rtl/bam_run_unit.sv]
// ---------------------------------------------------------------------------
// bam_run_unit
// First-fit run tracker over one 8-bit chunk of the map, with carried run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bam_run_unit (
    input  logic [bam_pkg::CHUNK_W-1:0] i_chunk,
    input  logic [bam_pkg::POS_W-1:0]   i_base,
    input  logic [bam_pkg::RUN_W-1:0]   i_run,
    input  logic [bam_pkg::POS_W-1:0]   i_first,
    input  logic [bam_pkg::CNT_W-1:0]   i_count,
    output bam_pkg::t_run_res           o_res
);
    import bam_pkg::*;

    always_comb begin
        logic [LR_W-1:0]  lr;
        logic             all_free;
        logic [RUN_W-1:0] run_j;
        logic [POS_W-1:0] first_j;
        lr       = '0;
        all_free = 1'b1;
        run_j    = '0;
        first_j  = '0;
        o_res    = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            if (i_chunk[j]) begin
                lr       = '0;
                all_free = 1'b0;
            end else begin
                lr = lr + LR_W'(1);
            end
            run_j = all_free ? (i_run + RUN_W'(lr)) : RUN_W'(lr);
            if (all_free) begin
                first_j = (i_run == '0) ? i_base : i_first;
            end else begin
                first_j = i_base + POS_W'(j + 1) - POS_W'(lr);
            end
            if (!i_chunk[j] && (run_j == RUN_W'(i_count)) && !o_res.found) begin
                o_res.found = 1'b1;
                o_res.start = first_j;
            end
        end
        o_res.run   = run_j;
        o_res.first = first_j;
    end

endmodule

[rtl/bitmap_allocation_map.sv]
// ---------------------------------------------------------------------------
// bitmap_allocation_map
// Bit-per-unit allocation map: clear, test, set, first-fit scan, range set.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  cmd       in   i_cmd_valid / o_cmd_ready   i_command i_bit_index i_count i_value
//  res       out  o_res_valid / i_res_ready   o_ok o_bit_state o_start_index
//  cfg       in   i_cfg_we (no wait)          i_cfg_data (map_bytes)
//
//  Map lives in a 64-bit wide RAM of ceil(MAP_BYTES/8) words, one port each side.
//  Test: a word read, then the bit is taken. Set and range set: a read and a write
//  per word touched. Scan: a word read, then one step per 8-bit chunk; a miss adds
//  an end check, and a read when the map ends on a word edge. Clear and reset: a
//  clearing pass over all ceil(MAP_BYTES/8) words, no item taken. One item at a
//  time; a stalled result holds the sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bitmap_allocation_map #(
    parameter int MAP_BYTES = bam_pkg::MAP_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bam_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  logic [bam_pkg::CMD_W-1:0]   i_command,
    input  logic [bam_pkg::IDX_W-1:0]   i_bit_index,
    input  logic [bam_pkg::CNT_W-1:0]   i_count,
    input  logic                        i_value,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic                        o_ok,
    output logic                        o_bit_state,
    output logic [bam_pkg::IDX_W-1:0]   o_start_index
);
    import bam_pkg::*;

    localparam int WORDS = (MAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [WAW-1:0] LAST_ADDR = WAW'(WORDS - 1);
    localparam logic [8:0]     CAP_BYTES = (MAP_BYTES > 255) ? 9'd255 : 9'(MAP_BYTES);

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_map_bytes;
    logic [8:0]        eff_bytes;
    logic [POS_W-1:0]  map_bits;

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORD_W-1:0] r_rdata;
    logic              mem_re, mem_we;
    logic [WAW-1:0]    mem_raddr, mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WAW-1:0]    r_clr_addr;
    logic              clr_last;

    logic [OFF_W-1:0]  r_lo, r_hi;
    logic [WIDX_W-1:0] r_word, r_wlast;
    logic              r_first_word;
    logic              r_val;
    logic [CNT_W-1:0]  r_cnt;
    logic [CSEL_W-1:0] r_chunk;
    logic [RUN_W-1:0]  r_run;
    logic [POS_W-1:0]  r_first;
    logic              r_ok, r_st;
    logic [IDX_W-1:0]  r_start;

    logic              r_res_valid, r_res_ok, r_res_st;
    logic [IDX_W-1:0]  r_res_start;

    logic              acc, load_res;
    logic [CNT_W-1:0]  ecnt;
    logic [RUN_W-1:0]  span_end, last_pos;
    logic              fits, idx_in;
    logic [WAW+WIDX_W-1:0] word_ext;
    logic [WAW-1:0]    word_addr;
    logic [OFF_W-1:0]  lo_off, hi_off;
    logic [WORD_W-1:0] wmask, merged;
    logic [POS_W-1:0]  scan_base;
    logic              scan_end;
    t_run_res          run_res;

    assign eff_bytes = ({1'b0, r_map_bytes} > CAP_BYTES) ? CAP_BYTES : {1'b0, r_map_bytes};
    assign map_bits  = {eff_bytes[7:0], 3'b000};

    assign acc      = i_cmd_valid && o_cmd_ready;
    assign ecnt     = (i_command == CMD_SET) ? CNT_W'(1) : i_count;
    assign span_end = RUN_W'(i_bit_index) + RUN_W'(ecnt);
    assign last_pos = span_end - RUN_W'(1);
    assign fits     = span_end <= RUN_W'(map_bits);
    assign idx_in   = POS_W'(i_bit_index) < map_bits;

    assign word_ext  = {{WAW{1'b0}}, r_word};
    assign word_addr = word_ext[WAW-1:0];
    assign clr_last  = r_clr_addr == LAST_ADDR;

    assign lo_off = r_first_word ? r_lo : '0;
    assign hi_off = (r_word == r_wlast) ? r_hi : OFF_MAX;
    assign wmask  = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (OFF_MAX - hi_off));
    assign merged = r_val ? (r_rdata | wmask) : (r_rdata & ~wmask);

    assign scan_base = {r_word, r_chunk, 3'b000};
    assign scan_end  = scan_base >= map_bits;

    bam_run_unit u_run (
        .i_chunk (r_rdata[{r_chunk, 3'b000} +: CHUNK_W]),
        .i_base  (scan_base),
        .i_run   (r_run),
        .i_first (r_first),
        .i_count (r_cnt),
        .o_res   (run_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_CLR: begin
                if (clr_last) n_state = S_FIN;
            end
            S_IDLE: begin
                if (acc) begin
                    case (i_command)
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_TEST:  n_state = idx_in ? S_TEST_RD : S_FIN;
                        CMD_SET:   n_state = idx_in ? S_RNG_RD : S_FIN;
                        CMD_SCAN:  n_state = (i_count != '0) ? S_SCAN_RD : S_FIN;
                        CMD_RANGE: n_state = (fits && i_count != '0) ? S_RNG_RD : S_FIN;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_TEST_RD:  n_state = S_TEST_DAT;
            S_TEST_DAT: n_state = S_FIN;
            S_RNG_RD:   n_state = S_RNG_WR;
            S_RNG_WR: begin
                if (r_word == r_wlast) n_state = S_FIN;
                else n_state = S_RNG_RD;
            end
            S_SCAN_RD:  n_state = S_SCAN_RUN;
            S_SCAN_RUN: begin
                if (scan_end || run_res.found) n_state = S_FIN;
                else if (r_chunk == LAST_CHUNK) n_state = S_SCAN_RD;
            end
            S_FIN: begin
                if (load_res) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_cmd_ready = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_raddr   = word_addr;
        mem_waddr   = word_addr;
        mem_wdata   = merged;
        load_res    = 1'b0;
        case (r_state)
            S_INIT, S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_IDLE:    o_cmd_ready = 1'b1;
            S_TEST_RD, S_RNG_RD, S_SCAN_RD: mem_re = 1'b1;
            S_RNG_WR:  mem_we = 1'b1;
            S_FIN:     load_res = !r_res_valid || i_res_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_addr  <= '0;
            r_map_bytes <= MAP_BYTES_RST;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_map_bytes <= i_cfg_data;
            if (r_state == S_INIT || r_state == S_CLR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + WAW'(1);
            end
            if (load_res) r_res_valid <= 1'b1;
            else if (i_res_ready) r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    r_val        <= i_value;
                    r_cnt        <= i_count;
                    r_lo         <= i_bit_index[OFF_W-1:0];
                    r_hi         <= last_pos[OFF_W-1:0];
                    r_wlast      <= last_pos[OFF_W +: WIDX_W];
                    r_word       <= (i_command == CMD_SCAN) ? '0
                                    : WIDX_W'(i_bit_index[IDX_W-1:OFF_W]);
                    r_first_word <= 1'b1;
                    r_chunk      <= '0;
                    r_run        <= '0;
                    r_first      <= '0;
                    r_st         <= (i_command == CMD_TEST) && !idx_in;
                    r_start      <= '0;
                    case (i_command)
                        CMD_CLEAR: r_ok <= 1'b1;
                        CMD_SET:   r_ok <= idx_in;
                        CMD_RANGE: r_ok <= fits;
                        default:   r_ok <= 1'b0;
                    endcase
                end
            end
            S_TEST_DAT: begin
                r_st <= r_rdata[r_lo];
                r_ok <= 1'b1;
            end
            S_RNG_WR: begin
                r_word       <= r_word + WIDX_W'(1);
                r_first_word <= 1'b0;
            end
            S_SCAN_RUN: begin
                if (!scan_end) begin
                    if (run_res.found) begin
                        r_ok    <= 1'b1;
                        r_start <= run_res.start[IDX_W-1:0];
                    end else begin
                        r_run   <= run_res.run;
                        r_first <= run_res.first;
                        r_chunk <= r_chunk + CSEL_W'(1);
                        if (r_chunk == LAST_CHUNK) r_word <= r_word + WIDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_res_ok    <= r_ok;
            r_res_st    <= r_st;
            r_res_start <= r_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    assign o_res_valid   = r_res_valid;
    assign o_ok          = r_res_ok;
    assign o_bit_state   = r_res_st;
    assign o_start_index = r_res_start;

    `BAM_CHECK(a_no_write_idle, i_clk, i_rst_n, (r_state == S_IDLE) |-> !mem_we, "map write while idle")
    `BAM_CHECK(a_busy_after_item, i_clk, i_rst_n, acc |=> !o_cmd_ready, "ready right after an item")
    `BAM_CHECK(a_range_bound, i_clk, i_rst_n, (r_state == S_RNG_WR) |-> (r_word <= r_wlast), "range write past last word")
    `BAM_CHECK(a_scan_stop, i_clk, i_rst_n, (r_state == S_SCAN_RUN && scan_end) |=> (r_state == S_FIN), "scan ran past map end")
    `BAM_NEVER(a_port_clash, i_clk, i_rst_n, mem_re && mem_we, "map read and write in one cycle")

endmodule
